>>> rtl/core/limit_crossing_event_detector_macros.svh
// assertion macros used by the checker file
`ifndef LIMIT_CROSSING_EVENT_DETECTOR_MACROS_SVH
`define LIMIT_CROSSING_EVENT_DETECTOR_MACROS_SVH

// property checked on every clock edge outside reset
`define LCED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property that must also hold while reset is applied
`define LCED_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/core/lced_pkg.sv
`timescale 1ns / 1ps
package lced_pkg;

    localparam int NUM_TYPES   = 2;
    localparam int VALUE_WIDTH = 32;
    localparam int LIMIT_W     = 32;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int FLAGS_W     = 8;
    localparam int FLAGS_PER_TYPE = 4;
    localparam int EV_KINDS    = 5;
    localparam int EV_MASK_W   = NUM_TYPES * EV_KINDS;
    localparam int EV_SEL_W    = $clog2(EV_MASK_W);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 8;
    localparam int LOG_TYPE_W  = 1;
    localparam int CODE_W      = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_FLAGS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BELOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ABOVE       = 3'd5;

    // flag bit positions within one type's group
    localparam int FLAG_CHANGED = 0;
    localparam int FLAG_BELOW   = 1;
    localparam int FLAG_WINDOW  = 2;
    localparam int FLAG_ABOVE   = 3;

    // event codes, also the bit position within one type's event mask
    typedef enum logic [CODE_W-1:0] {
        EV_CHANGED = 3'd0,
        EV_BELOW   = 3'd1,
        EV_WINDOW  = 3'd2,
        EV_NORMAL  = 3'd3,
        EV_ABOVE   = 3'd4
    } event_code_t;

    typedef logic [EV_MASK_W-1:0] ev_mask_t;

    // one sample's events, front to queue and queue to back
    typedef struct packed {
        logic     valid;
        ev_mask_t mask;
    } ev_req_t;

endpackage

>>> rtl/core/lced_fifo.sv
`timescale 1ns / 1ps
module lced_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  lced_pkg::ev_req_t push_req,
    output logic             full,
    output lced_pkg::ev_req_t head,
    input  logic             pop
);
    import lced_pkg::*;

    ev_mask_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic                    do_push, do_pop;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign do_push  = push_req.valid && !full;
    assign do_pop   = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.mask  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_req.mask;
        end
    end

endmodule

>>> rtl/core/lced_front.sv
`timescale 1ns / 1ps
module lced_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lced_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          cfg_we,
    input  logic [lced_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lced_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          queue_full,
    output lced_pkg::ev_req_t              push_req
);
    import lced_pkg::*;

    logic                     enable_reg;
    logic [FLAGS_W-1:0]       flags_reg;
    logic [CFG_W-1:0]         below_reg, win_low_reg, win_high_reg, above_reg;
    logic signed [LIMIT_W-1:0] prev_reg;
    logic                     seen_reg;

    logic signed [LIMIT_W-1:0] sample;
    logic                     accept;
    ev_mask_t                 mask;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    // only the low VALUE_WIDTH bits count, sign-extended to limit width
    assign sample   = LIMIT_W'($signed(s_tdata[VALUE_WIDTH-1:0]));

    always_comb begin
        logic [FLAGS_PER_TYPE-1:0] f;
        logic signed [LIMIT_W-1:0] lb, wl, wh, la;
        logic below_ent, win_ent, above_ent;
        logic norm_b, norm_w, norm_a;
        logic vin, pin;
        mask = '0;
        for (int t = 0; t < NUM_TYPES; t++) begin
            f  = flags_reg[t*FLAGS_PER_TYPE +: FLAGS_PER_TYPE];
            lb = $signed(below_reg[t*LIMIT_W +: LIMIT_W]);
            wl = $signed(win_low_reg[t*LIMIT_W +: LIMIT_W]);
            wh = $signed(win_high_reg[t*LIMIT_W +: LIMIT_W]);
            la = $signed(above_reg[t*LIMIT_W +: LIMIT_W]);

            below_ent = f[FLAG_BELOW] && (sample < lb) && (!seen_reg || prev_reg >= lb);
            norm_b    = f[FLAG_BELOW] && !below_ent && seen_reg
                        && (sample > lb) && (prev_reg <= lb);

            vin     = (sample >= wl) && (sample <= wh);
            pin     = (prev_reg >= wl) && (prev_reg <= wh);
            win_ent = f[FLAG_WINDOW] && vin && (!seen_reg || !pin);
            norm_w  = f[FLAG_WINDOW] && !win_ent && seen_reg && !vin && pin;

            above_ent = f[FLAG_ABOVE] && (sample > la) && (!seen_reg || prev_reg <= la);
            norm_a    = f[FLAG_ABOVE] && !above_ent && seen_reg
                        && (sample < la) && (prev_reg >= la);

            mask[t*EV_KINDS + int'(EV_CHANGED)] = f[FLAG_CHANGED]
                                                  && (!seen_reg || prev_reg != sample);
            mask[t*EV_KINDS + int'(EV_BELOW)]   = below_ent;
            mask[t*EV_KINDS + int'(EV_WINDOW)]  = win_ent;
            // return to normal is held back when any limit was entered
            mask[t*EV_KINDS + int'(EV_NORMAL)]  = (norm_b || norm_w || norm_a)
                                                  && !(below_ent || win_ent || above_ent);
            mask[t*EV_KINDS + int'(EV_ABOVE)]   = above_ent;
        end
    end

    assign push_req.valid = accept && enable_reg && (mask != '0);
    assign push_req.mask  = mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b1;
            flags_reg    <= '0;
            below_reg    <= '0;
            win_low_reg  <= '0;
            win_high_reg <= '0;
            above_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ENABLE:      enable_reg   <= cfg_wdata[0];
                CFG_EVENT_FLAGS: flags_reg    <= cfg_wdata[FLAGS_W-1:0];
                CFG_BELOW:       below_reg    <= cfg_wdata;
                CFG_WIN_LOW:     win_low_reg  <= cfg_wdata;
                CFG_WIN_HIGH:    win_high_reg <= cfg_wdata;
                CFG_ABOVE:       above_reg    <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            seen_reg <= 1'b0;
        end else if (accept && enable_reg) begin
            prev_reg <= sample;
            seen_reg <= 1'b1;
        end
    end

endmodule

>>> rtl/core/lced_back.sv
`timescale 1ns / 1ps
module lced_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lced_pkg::ev_req_t              head,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lced_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [lced_pkg::LOG_TYPE_W-1:0] m_tuser,
    output logic                           m_tlast
);
    import lced_pkg::*;

    ev_mask_t                 pend_reg, pend_next;
    logic                     valid_reg, valid_next;
    logic [CODE_W-1:0]        code_reg, code_next;
    logic [LOG_TYPE_W-1:0]    type_reg, type_next;
    logic                     last_reg, last_next;
    logic [EV_SEL_W-1:0]      sel;
    ev_mask_t                 rest;
    logic                     out_free;

    assign out_free = !valid_reg || m_tready;

    // lowest pending bit is the next event in order
    always_comb begin
        sel = '0;
        for (int i = EV_MASK_W - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel = EV_SEL_W'(i);
            end
        end
        rest = pend_reg & ~(ev_mask_t'(1) << sel);
    end

    always_comb begin
        pend_next  = pend_reg;
        valid_next = valid_reg && !m_tready;
        code_next  = code_reg;
        type_next  = type_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (pend_reg != '0) begin
            if (out_free) begin
                valid_next = 1'b1;
                last_next  = (rest == '0);
                pend_next  = rest;
                if (sel >= EV_SEL_W'(EV_KINDS)) begin
                    type_next = LOG_TYPE_W'(1);
                    code_next = CODE_W'(sel - EV_SEL_W'(EV_KINDS));
                end else begin
                    type_next = '0;
                    code_next = CODE_W'(sel);
                end
            end
        end else if (head.valid) begin
            pend_next = head.mask;
            pop       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        type_reg <= type_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_DATA_W'(code_reg);
    assign m_tuser  = type_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/core/limit_crossing_event_detector.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: sample_value
// m_        out  m_tvalid/m_tready  m_tdata: event_code, m_tuser: log_type, m_tlast: last
// cfg_      in   cfg_we             cfg_index, cfg_wdata
//
// a sample is classified in the cycle it is taken; its events wait in a four-deep queue
// the event sequencer loads one queued sample, then gives one event a cycle while the result
// register is free; a sample raises k events (k at most 8), all given before the next is loaded
// samples are taken one a cycle while the queue has room; no clearing pass after reset
// a stalled result register blocks the sequencer; the sample side is held only once the queue is full
module limit_crossing_event_detector (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lced_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] sample_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lced_pkg::OUT_DATA_W-1:0] m_tdata,   // [2:0] event_code, [7:3] zero
    output logic [lced_pkg::LOG_TYPE_W-1:0] m_tuser,   // [0] log_type
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [lced_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lced_pkg::CFG_W-1:0]      cfg_wdata
);
    import lced_pkg::*;

    ev_req_t push_req;
    ev_req_t head;
    logic    queue_full;
    logic    pop;

    lced_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .queue_full (queue_full),
        .push_req   (push_req)
    );

    lced_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_req (push_req),
        .full     (queue_full),
        .head     (head),
        .pop      (pop)
    );

    lced_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/core/lced_checker.sv
`timescale 1ns / 1ps
`include "limit_crossing_event_detector_macros.svh"
module lced_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lced_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [lced_pkg::LOG_TYPE_W-1:0] m_tuser,
    input logic                            m_tlast
);
    import lced_pkg::*;

    logic code_ok;
    logic pad_zero;

    assign code_ok  = (m_tdata[CODE_W-1:0] == EV_CHANGED) || (m_tdata[CODE_W-1:0] == EV_BELOW)
                   || (m_tdata[CODE_W-1:0] == EV_WINDOW) || (m_tdata[CODE_W-1:0] == EV_NORMAL)
                   || (m_tdata[CODE_W-1:0] == EV_ABOVE);
    assign pad_zero = (m_tdata[OUT_DATA_W-1:CODE_W] == '0);

    `LCED_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result request changed while stalled")
    `LCED_ASSERT_RST(a_rst_idle, !aresetn |=> !m_tvalid, "result valid after reset")
    `LCED_ASSERT(a_code, m_tvalid |-> code_ok && pad_zero, "bad event code on result")

endmodule

bind limit_crossing_event_detector lced_checker u_lced_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
